FILE: hw/rtl/cprc_pkg.sv
// ----------------------------------------------------------------------------
// cprc_pkg - shared constants for the convex polygon ray cast
// fixed-point widths, saturation limits and configuration register indexes
// ----------------------------------------------------------------------------
`default_nettype none

package cprc_pkg;

  localparam int UNIT_WIDTH = 18;
  localparam int FRAC_WIDTH = 25;
  localparam int FRAC_MAX   = 16777216;
  localparam int UNIT_MAX   = 65536;
  localparam int BND_WIDTH  = FRAC_WIDTH + 2;

  typedef enum logic [2:0] {
    REG_EDGE_COUNT = 3'd0,
    REG_ROT_COS    = 3'd1,
    REG_ROT_SIN    = 3'd2,
    REG_POS_X      = 3'd3,
    REG_POS_Y      = 3'd4
  } cfg_reg_t;

endpackage

`default_nettype wire

FILE: hw/rtl/cprc_div.sv
// ----------------------------------------------------------------------------
// cprc_div - saturating restoring divider for clip fractions
// one quotient bit per cycle; quotients of 2^25 or more saturate to 2^25
// ----------------------------------------------------------------------------
`default_nettype none

module cprc_div #(
  parameter int N_W = 56,
  parameter int D_W = 40
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [N_W-1:0]                      n_mag,
  input  logic [D_W-1:0]                      d_mag,
  input  logic                                neg,
  output logic                                done,
  output logic signed [cprc_pkg::BND_WIDTH-1:0] quot
);

  localparam int QB    = cprc_pkg::FRAC_WIDTH + 1;
  localparam int SH_W  = (N_W > D_W + QB - 1) ? N_W : D_W + QB - 1;
  localparam int CNT_W = $clog2(QB);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [SH_W-1:0]  rem;
  logic [SH_W-1:0]  dsh;
  logic [QB-1:0]    q;
  logic             qneg;
  logic             ge;
  logic signed [cprc_pkg::BND_WIDTH-1:0] q_ext;

  assign ge    = (rem >= dsh);
  assign q_ext = signed'(cprc_pkg::BND_WIDTH'(q));
  assign quot  = qneg ? -q_ext : q_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= SH_W'(n_mag);
        dsh  <= SH_W'(d_mag) << (QB - 1);
        cnt  <= '0;
        q    <= '0;
        qneg <= neg;
        busy <= 1'b1;
      end else if (busy) begin
        dsh <= dsh >> 1;
        cnt <= cnt + 1'b1;
        if (ge) begin
          rem <= rem - dsh;
        end
        if (cnt == '0 && ge) begin
          // top bit set: quotient out of fraction range, saturate
          q    <= QB'(1) << (QB - 1);
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          q <= {q[QB-2:0], ge};
          if (cnt == CNT_W'(QB - 1)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/convex_polygon_ray_cast.sv
// ----------------------------------------------------------------------------
// convex_polygon_ray_cast - ray segment against a convex polygon, Q16.16
// cyrus-beck clipping of a world-frame segment against a loaded edge table
// ----------------------------------------------------------------------------
// A load item writes one edge slot and gives no result. A query item runs
// through these steps for the edges in use, ending early on a miss: the
// frame transform, the segment delta, per edge the vertex offset, the two dot
// products, one test, the bound compare unless the edge is parallel and the
// fraction division when the compare calls for it, then the world normal of
// the entry edge and the posting of the result; after that the next item
// can be taken. All products go through one shared multiply-accumulate
// unit (a registered product, then an accumulate) and all divisions through one
// bit-serial divider, so these units set the item time. The block takes no
// item while a query runs; a finished result sits in the output register
// while the next item is taken.
`default_nettype none

module convex_polygon_ray_cast #(
  parameter int MAX_EDGES   = 8,
  parameter int COORD_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  // configuration
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [((COORD_WIDTH > cprc_pkg::UNIT_WIDTH) ? COORD_WIDTH
                 : cprc_pkg::UNIT_WIDTH)-1:0] cfg_data,
  // input items
  input  logic in_valid,
  output logic in_ready,
  input  logic req_type,
  input  logic [2:0] edge_index,
  input  logic signed [COORD_WIDTH-1:0] vertex_x,
  input  logic signed [COORD_WIDTH-1:0] vertex_y,
  input  logic signed [cprc_pkg::UNIT_WIDTH-1:0] normal_x,
  input  logic signed [cprc_pkg::UNIT_WIDTH-1:0] normal_y,
  input  logic signed [COORD_WIDTH-1:0] ray_start_x,
  input  logic signed [COORD_WIDTH-1:0] ray_start_y,
  input  logic signed [COORD_WIDTH-1:0] ray_end_x,
  input  logic signed [COORD_WIDTH-1:0] ray_end_y,
  input  logic [cprc_pkg::FRAC_WIDTH-1:0] max_fraction,
  // result items
  output logic out_valid,
  input  logic out_ready,
  output logic hit,
  output logic [cprc_pkg::FRAC_WIDTH-1:0] hit_fraction,
  output logic signed [cprc_pkg::UNIT_WIDTH-1:0] hit_normal_x,
  output logic signed [cprc_pkg::UNIT_WIDTH-1:0] hit_normal_y
);

  localparam int UW    = cprc_pkg::UNIT_WIDTH;
  localparam int FW    = cprc_pkg::FRAC_WIDTH;
  localparam int BW    = cprc_pkg::BND_WIDTH;
  // value widths through the query
  localparam int T_W   = COORD_WIDTH + 1;   // world point minus position
  localparam int LOC_W = COORD_WIDTH + 4;   // local point
  localparam int D_W   = COORD_WIDTH + 5;   // segment delta, vertex offset
  localparam int NUM_W = COORD_WIDTH + 8;   // numerator, denominator
  localparam int SC_W  = NUM_W + 16;        // scaled numerator
  localparam int A_W   = BW;
  localparam int B_W   = NUM_W;
  localparam int P_W   = A_W + B_W;
  // index widths
  localparam int AW    = $clog2(MAX_EDGES);
  localparam int CW    = $clog2(MAX_EDGES + 1);
  localparam int IW    = (CW > 3) ? CW : 3;
  localparam int EW    = (CW > 4) ? CW : 4;

  typedef enum logic [3:0] {
    S_IDLE, S_ROT, S_DELTA, S_EDIFF, S_DOT, S_TEST, S_CMP, S_DIV, S_NORM, S_OUT
  } state_t;

  state_t state;

  // configuration registers
  logic [3:0]              ecnt;
  logic signed [UW-1:0]    rc, rs;
  logic signed [COORD_WIDTH-1:0] px, py;

  // edge table
  logic signed [COORD_WIDTH-1:0] ev_x [MAX_EDGES];
  logic signed [COORD_WIDTH-1:0] ev_y [MAX_EDGES];
  logic signed [UW-1:0]          en_x [MAX_EDGES];
  logic signed [UW-1:0]          en_y [MAX_EDGES];

  // query working registers
  logic signed [T_W-1:0]   tx1, ty1, tx2, ty2;
  logic signed [LOC_W-1:0] lx1, ly1, lx2, ly2;
  logic signed [D_W-1:0]   dx, dy, ex, ey;
  logic signed [UW-1:0]    nx_c, ny_c, fnx, fny;
  logic signed [NUM_W-1:0] num, den;
  logic signed [BW-1:0]    lower, upper;
  logic [CW-1:0]           cnt, idx;
  logic                    found;
  logic [2:0]              k;
  logic                    ph;

  // result staging and output register
  logic                    rhit;
  logic [FW-1:0]           rfrac;
  logic signed [UW-1:0]    rwx, rwy;

  // shared multiply-accumulate unit
  logic signed [A_W-1:0]   mul_a;
  logic signed [B_W-1:0]   mul_b;
  logic                    mul_neg;
  logic signed [P_W-1:0]   prod;
  logic signed [P_W-1:0]   prod_c;
  logic signed [P_W:0]     acc, acc_add, acc_new, acc_sh;
  logic signed [UW-1:0]    unit_c;

  logic [CW-1:0]           cnt_c;
  logic [IW-1:0]           load_idx;
  logic                    last_edge;
  logic signed [P_W:0]     scaled_c;
  logic [NUM_W-1:0]        num_abs, den_abs;
  logic                    div_start, div_done;
  logic signed [BW-1:0]    quot;

  assign in_ready  = (state == S_IDLE);
  assign load_idx  = IW'(edge_index);
  assign cnt_c     = (EW'(ecnt) > EW'(MAX_EDGES)) ? CW'(MAX_EDGES) : CW'(ecnt);
  assign last_edge = ((idx + 1'b1) == cnt);

  // operand select per step
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    case (state)
      S_ROT: begin
        case (k)
          3'd0: begin mul_a = A_W'(rc); mul_b = B_W'(tx1); end
          3'd1: begin mul_a = A_W'(rs); mul_b = B_W'(ty1); end
          3'd2: begin mul_a = A_W'(rc); mul_b = B_W'(ty1); end
          3'd3: begin mul_a = A_W'(rs); mul_b = B_W'(tx1); mul_neg = 1'b1; end
          3'd4: begin mul_a = A_W'(rc); mul_b = B_W'(tx2); end
          3'd5: begin mul_a = A_W'(rs); mul_b = B_W'(ty2); end
          3'd6: begin mul_a = A_W'(rc); mul_b = B_W'(ty2); end
          default: begin mul_a = A_W'(rs); mul_b = B_W'(tx2); mul_neg = 1'b1; end
        endcase
      end
      S_DOT: begin
        case (k[1:0])
          2'd0:    begin mul_a = A_W'(nx_c); mul_b = B_W'(ex); end
          2'd1:    begin mul_a = A_W'(ny_c); mul_b = B_W'(ey); end
          2'd2:    begin mul_a = A_W'(nx_c); mul_b = B_W'(dx); end
          default: begin mul_a = A_W'(ny_c); mul_b = B_W'(dy); end
        endcase
      end
      S_CMP: begin
        mul_a = den[NUM_W-1] ? lower : upper;
        mul_b = den;
      end
      S_NORM: begin
        case (k[1:0])
          2'd0:    begin mul_a = A_W'(rc); mul_b = B_W'(fnx); end
          2'd1:    begin mul_a = A_W'(rs); mul_b = B_W'(fny); mul_neg = 1'b1; end
          2'd2:    begin mul_a = A_W'(rs); mul_b = B_W'(fnx); end
          default: begin mul_a = A_W'(rc); mul_b = B_W'(fny); end
        endcase
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign prod_c  = mul_a * mul_b;
  assign acc_add = mul_neg ? -((P_W+1)'(prod)) : (P_W+1)'(prod);
  // second term of a pair adds onto the first
  assign acc_new = (k[0] ? acc : '0) + acc_add;
  assign acc_sh  = acc_new >>> 16;

  // world normal saturated to the unit range
  always_comb begin
    if (acc_sh > (P_W+1)'(cprc_pkg::UNIT_MAX)) begin
      unit_c = UW'(cprc_pkg::UNIT_MAX);
    end else if (acc_sh < -((P_W+1)'(cprc_pkg::UNIT_MAX))) begin
      unit_c = -(UW'(cprc_pkg::UNIT_MAX));
    end else begin
      unit_c = UW'(acc_sh);
    end
  end

  assign scaled_c  = (P_W+1)'(num) <<< 16;
  assign num_abs   = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign den_abs   = den[NUM_W-1] ? NUM_W'(-den) : NUM_W'(den);
  assign div_start = (state == S_CMP) && ph && (scaled_c < (P_W+1)'(prod));

  cprc_div #(
    .N_W (SC_W),
    .D_W (NUM_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .n_mag ({num_abs, 16'd0}),
    .d_mag (den_abs),
    .neg   (num[NUM_W-1] ^ den[NUM_W-1]),
    .done  (div_done),
    .quot  (quot)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ecnt <= 4'd3;
      rc   <= UW'(cprc_pkg::UNIT_MAX);
      rs   <= '0;
      px   <= '0;
      py   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cprc_pkg::REG_EDGE_COUNT: ecnt <= cfg_data[3:0];
        cprc_pkg::REG_ROT_COS:    rc   <= signed'(cfg_data[UW-1:0]);
        cprc_pkg::REG_ROT_SIN:    rs   <= signed'(cfg_data[UW-1:0]);
        cprc_pkg::REG_POS_X:      px   <= signed'(cfg_data[COORD_WIDTH-1:0]);
        cprc_pkg::REG_POS_Y:      py   <= signed'(cfg_data[COORD_WIDTH-1:0]);
        default: ;
      endcase
    end
  end

  // edge table: written by loads, read one slot per edge step
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid && !req_type && load_idx < IW'(MAX_EDGES)) begin
      ev_x[load_idx[AW-1:0]] <= vertex_x;
      ev_y[load_idx[AW-1:0]] <= vertex_y;
      en_x[load_idx[AW-1:0]] <= normal_x;
      en_y[load_idx[AW-1:0]] <= normal_y;
    end
    if (state == S_EDIFF) begin
      ex   <= D_W'(ev_x[idx[AW-1:0]]) - D_W'(lx1);
      ey   <= D_W'(ev_y[idx[AW-1:0]]) - D_W'(ly1);
      nx_c <= en_x[idx[AW-1:0]];
      ny_c <= en_y[idx[AW-1:0]];
    end
  end

  // query sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      k         <= '0;
      ph        <= 1'b0;
      found     <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && req_type) begin
            tx1   <= T_W'(ray_start_x) - T_W'(px);
            ty1   <= T_W'(ray_start_y) - T_W'(py);
            tx2   <= T_W'(ray_end_x) - T_W'(px);
            ty2   <= T_W'(ray_end_y) - T_W'(py);
            lower <= '0;
            upper <= (max_fraction > FW'(cprc_pkg::FRAC_MAX))
                     ? BW'(cprc_pkg::FRAC_MAX) : signed'(BW'(max_fraction));
            found <= 1'b0;
            k     <= '0;
            ph    <= 1'b0;
            state <= S_ROT;
          end
        end
        S_ROT: begin
          // world to local: lx = c*tx + s*ty, ly = c*ty - s*tx
          if (!ph) begin
            prod <= prod_c;
            ph   <= 1'b1;
          end else begin
            acc <= acc_new;
            ph  <= 1'b0;
            k   <= k + 1'b1;
            case (k)
              3'd1:    lx1 <= LOC_W'(acc_sh);
              3'd3:    ly1 <= LOC_W'(acc_sh);
              3'd5:    lx2 <= LOC_W'(acc_sh);
              3'd7:    ly2 <= LOC_W'(acc_sh);
              default: ;
            endcase
            if (k == 3'd7) begin
              state <= S_DELTA;
            end
          end
        end
        S_DELTA: begin
          dx  <= D_W'(lx2) - D_W'(lx1);
          dy  <= D_W'(ly2) - D_W'(ly1);
          cnt <= cnt_c;
          idx <= '0;
          if (cnt_c == '0) begin
            rhit  <= 1'b0;
            rfrac <= '0;
            rwx   <= '0;
            rwy   <= '0;
            state <= S_OUT;
          end else begin
            state <= S_EDIFF;
          end
        end
        S_EDIFF: begin
          k     <= '0;
          ph    <= 1'b0;
          state <= S_DOT;
        end
        S_DOT: begin
          // numerator n.(v - p1), then denominator n.d
          if (!ph) begin
            prod <= prod_c;
            ph   <= 1'b1;
          end else begin
            acc <= acc_new;
            ph  <= 1'b0;
            k   <= k + 1'b1;
            if (k[1:0] == 2'd1) begin
              num <= NUM_W'(acc_sh);
            end
            if (k[1:0] == 2'd3) begin
              den   <= NUM_W'(acc_sh);
              state <= S_TEST;
            end
          end
        end
        S_TEST: begin
          k  <= '0;
          ph <= 1'b0;
          if (den == '0) begin
            // parallel edge: outside means miss
            if (num[NUM_W-1]) begin
              rhit  <= 1'b0;
              rfrac <= '0;
              rwx   <= '0;
              rwy   <= '0;
              state <= S_OUT;
            end else if (last_edge) begin
              state <= found ? S_NORM : S_OUT;
              if (!found) begin
                rhit  <= 1'b0;
                rfrac <= '0;
                rwx   <= '0;
                rwy   <= '0;
              end
            end else begin
              idx   <= idx + 1'b1;
              state <= S_EDIFF;
            end
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          // bound*den against num*2^16, exact
          if (!ph) begin
            prod <= prod_c;
            ph   <= 1'b1;
          end else begin
            ph <= 1'b0;
            if (div_start) begin
              state <= S_DIV;
            end else if (last_edge) begin
              state <= found ? S_NORM : S_OUT;
              if (!found) begin
                rhit  <= 1'b0;
                rfrac <= '0;
                rwx   <= '0;
                rwy   <= '0;
              end
            end else begin
              idx   <= idx + 1'b1;
              state <= S_EDIFF;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (den[NUM_W-1]) begin
              // entering edge raises the lower bound
              lower <= quot;
              found <= 1'b1;
              fnx   <= nx_c;
              fny   <= ny_c;
            end else begin
              upper <= quot;
            end
            if (den[NUM_W-1] ? (quot > upper) : (quot < lower)) begin
              rhit  <= 1'b0;
              rfrac <= '0;
              rwx   <= '0;
              rwy   <= '0;
              state <= S_OUT;
            end else if (last_edge) begin
              if (found || den[NUM_W-1]) begin
                k     <= '0;
                ph    <= 1'b0;
                state <= S_NORM;
              end else begin
                rhit  <= 1'b0;
                rfrac <= '0;
                rwx   <= '0;
                rwy   <= '0;
                state <= S_OUT;
              end
            end else begin
              idx   <= idx + 1'b1;
              state <= S_EDIFF;
            end
          end
        end
        S_NORM: begin
          // rotate entry normal back to world frame
          if (!ph) begin
            prod <= prod_c;
            ph   <= 1'b1;
          end else begin
            acc <= acc_new;
            ph  <= 1'b0;
            k   <= k + 1'b1;
            if (k[1:0] == 2'd1) begin
              rwx <= unit_c;
            end
            if (k[1:0] == 2'd3) begin
              rwy   <= unit_c;
              rhit  <= 1'b1;
              rfrac <= (lower > BW'(cprc_pkg::FRAC_MAX))
                       ? FW'(cprc_pkg::FRAC_MAX) : FW'(lower);
              state <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            hit          <= rhit;
            hit_fraction <= rfrac;
            hit_normal_x <= rwx;
            hit_normal_y <= rwy;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // divider answers only while the sequencer waits on it
  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider done outside division step");

  // a surviving interval is ordered and non-negative at each compare
  a_bounds_ordered: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> (lower <= upper && !lower[BW-1]))
    else $error("clip interval out of order");

  // normal rotation only runs for a found entry edge
  a_norm_found: assert property (@(posedge clk) disable iff (rst)
    (state == S_NORM) |-> found)
    else $error("normal step without entry edge");

  // a result is only posted from the output step
  a_post_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_OUT))
    else $error("result posted outside output step");

endmodule

`default_nettype wire
